// ----- design/crrs_pkg.sv -----
// Package for the class-rotating round-robin scheduler.
// Holds task counts, widths, the class codes and the stream packing offsets.
// No dependencies.
`default_nettype none

package crrs_pkg;

    localparam int GROUP_TASKS  = 5;
    localparam int HELPER_TASKS = 15;

    localparam int MASK_W = (GROUP_TASKS > HELPER_TASKS) ? GROUP_TASKS : HELPER_TASKS;
    localparam int IDX_W  = (MASK_W > 1) ? $clog2(MASK_W) : 1;
    localparam int GRP_W  = $clog2(GROUP_TASKS);
    localparam int HLP_W  = $clog2(HELPER_TASKS);

    localparam int CLASS_W        = 2;
    localparam int CHOSEN_INDEX_W = 4;

    localparam int IN_BITS   = 2 * GROUP_TASKS + HELPER_TASKS;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_A_LO   = 0;
    localparam int IN_B_LO   = GROUP_TASKS;
    localparam int IN_H_LO   = 2 * GROUP_TASKS;

    localparam int OUT_BITS   = CLASS_W + CHOSEN_INDEX_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_A    = 2'd0,
        CLASS_B    = 2'd1,
        CLASS_H    = 2'd2,
        CLASS_NONE = 2'd3
    } t_class;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             hit;
    } t_step;

endpackage

`default_nettype wire

// ----- design/crrs_step.sv -----
// Shared scan step of the scheduler: advances a round-robin index with wrap
// and tests the alive bit at the new index. Depends on crrs_pkg.
`default_nettype none

module crrs_step
    import crrs_pkg::*;
(
    input  wire logic [MASK_W-1:0] i_mask,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire logic [IDX_W-1:0]  i_last,
    output t_step                  o_step
);

    logic [IDX_W-1:0] nxt;

    always_comb begin
        if (i_idx >= i_last) begin
            nxt = '0;
        end else begin
            nxt = i_idx + IDX_W'(1);
        end
        o_step.idx = nxt;
        o_step.hit = i_mask[nxt];
    end

endmodule

`default_nettype wire

// ----- design/class_rotating_round_robin_scheduler.sv -----
// Top level of the class-rotating round-robin scheduler.
// Uses crrs_pkg and the shared scan step crrs_step.
//
// One beat of alive masks yields one beat naming the chosen class and task.
// The class tried first rotates A, B, helper; a group scan that finds no
// alive task falls through to the helper scan. A single step unit examines
// one mask bit per cycle. The longest scan is a full group scan followed by
// a full helper scan. A finished result waits while the output register is
// full. The input is not ready while a scan runs or a result waits, and it
// is ready again once the result is registered.
`default_nettype none

module class_rotating_round_robin_scheduler
    import crrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // alive_a, alive_b, alive_h from bit 0 up, zero filled
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // chosen_class, chosen_index from bit 0 up, zero filled
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GRP  = 4'b0010,
        S_HLP  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    t_class                 r_cur, n_cur;
    logic [GRP_W-1:0]       r_pos_a, n_pos_a;
    logic [GRP_W-1:0]       r_pos_b, n_pos_b;
    logic [HLP_W-1:0]       r_pos_h, n_pos_h;
    logic                   r_grp_b, n_grp_b;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_cnt, n_cnt;
    logic [GROUP_TASKS-1:0] r_alive_a, n_alive_a;
    logic [GROUP_TASKS-1:0] r_alive_b, n_alive_b;
    logic [HELPER_TASKS-1:0] r_alive_h, n_alive_h;
    t_class                 r_res_class, n_res_class;
    logic [IDX_W-1:0]       r_res_idx, n_res_idx;
    logic                   r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0]  r_m_data, n_m_data;

    logic [MASK_W-1:0]      step_mask;
    logic [IDX_W-1:0]       step_last;
    t_step                  step;
    logic                   in_beat;
    logic                   out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_comb begin
        if (r_state == S_HLP) begin
            step_mask = MASK_W'(r_alive_h);
            step_last = IDX_W'(HELPER_TASKS - 1);
        end else begin
            step_mask = r_grp_b ? MASK_W'(r_alive_b) : MASK_W'(r_alive_a);
            step_last = IDX_W'(GROUP_TASKS - 1);
        end
    end

    crrs_step u_step (
        .i_mask (step_mask),
        .i_idx  (r_idx),
        .i_last (step_last),
        .o_step (step)
    );

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_pos_a     = r_pos_a;
        n_pos_b     = r_pos_b;
        n_pos_h     = r_pos_h;
        n_grp_b     = r_grp_b;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_alive_a   = r_alive_a;
        n_alive_b   = r_alive_b;
        n_alive_h   = r_alive_h;
        n_res_class = r_res_class;
        n_res_idx   = r_res_idx;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_alive_a = s_axis_tdata[IN_A_LO +: GROUP_TASKS];
                    n_alive_b = s_axis_tdata[IN_B_LO +: GROUP_TASKS];
                    n_alive_h = s_axis_tdata[IN_H_LO +: HELPER_TASKS];
                    n_cnt     = '0;
                    case (r_cur)
                        CLASS_A: begin
                            n_grp_b = 1'b1;
                            n_idx   = IDX_W'(r_pos_b);
                            n_state = S_GRP;
                        end
                        CLASS_B: begin
                            n_idx   = IDX_W'(r_pos_h);
                            n_state = S_HLP;
                        end
                        default: begin
                            n_grp_b = 1'b0;
                            n_idx   = IDX_W'(r_pos_a);
                            n_state = S_GRP;
                        end
                    endcase
                end
            end
            S_GRP: begin
                if (step.hit) begin
                    if (r_grp_b) begin
                        n_pos_b     = GRP_W'(step.idx);
                        n_cur       = CLASS_B;
                        n_res_class = CLASS_B;
                    end else begin
                        n_pos_a     = GRP_W'(step.idx);
                        n_cur       = CLASS_A;
                        n_res_class = CLASS_A;
                    end
                    n_res_idx = step.idx;
                    n_state   = S_EMIT;
                end else if (r_cnt == IDX_W'(GROUP_TASKS - 1)) begin
                    n_cnt   = '0;
                    n_idx   = IDX_W'(r_pos_h);
                    n_state = S_HLP;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                    n_idx = step.idx;
                end
            end
            S_HLP: begin
                if (step.hit) begin
                    n_pos_h     = HLP_W'(step.idx);
                    n_cur       = CLASS_H;
                    n_res_class = CLASS_H;
                    n_res_idx   = step.idx;
                    n_state     = S_EMIT;
                end else if (r_cnt == IDX_W'(HELPER_TASKS - 1)) begin
                    n_res_class = CLASS_NONE;
                    n_res_idx   = '0;
                    n_state     = S_EMIT;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                    n_idx = step.idx;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = OUT_DATA_W'({CHOSEN_INDEX_W'(r_res_idx), r_res_class});
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= CLASS_H;
            r_pos_a   <= '0;
            r_pos_b   <= '0;
            r_pos_h   <= '0;
            r_grp_b   <= 1'b0;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_pos_a   <= n_pos_a;
            r_pos_b   <= n_pos_b;
            r_pos_h   <= n_pos_h;
            r_grp_b   <= n_grp_b;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alive_a   <= n_alive_a;
        r_alive_b   <= n_alive_b;
        r_alive_h   <= n_alive_h;
        r_res_class <= n_res_class;
        r_res_idx   <= n_res_idx;
        r_m_data    <= n_m_data;
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the class-rotating round-robin scheduler.
// Drives alive-mask beats, predicts each chosen class and task, and compares
// every output beat. Depends on crrs_pkg and class_rotating_round_robin_scheduler.
`default_nettype none

module testbench;
    import crrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [GROUP_TASKS-1:0]  alive_a;
        logic [GROUP_TASKS-1:0]  alive_b;
        logic [HELPER_TASKS-1:0] alive_h;
        bit                      wait_drained;
        int                      gap;
    } t_tick;

    typedef struct {
        t_class                    cls;
        logic [CHOSEN_INDEX_W-1:0] idx;
    } t_choice;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_tick   tick_queue[$];
    t_choice expected_choices[$];
    t_tick   next_tick;

    t_class            last_class = CLASS_H;
    logic [GRP_W-1:0]  last_a = '0;
    logic [GRP_W-1:0]  last_b = '0;
    logic [HLP_W-1:0]  last_h = '0;

    logic tick_taken = 1'b0;
    logic choice_taken = 1'b0;
    logic hold_off = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   ticks_total = 0;
    int   ticks_in = 0;
    int   choices_out = 0;
    int   mismatches = 0;
    int   class_seen[4] = '{0, 0, 0, 0};

    class_rotating_round_robin_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [HELPER_TASKS-1:0] random_mask(input int width);
        int r;
        logic [HELPER_TASKS-1:0] full;
        r = $urandom_range(0, 99);
        full = (HELPER_TASKS)'((1 << width) - 1);
        if (r < 15) return '0;
        if (r < 40) return (HELPER_TASKS)'(1 << $urandom_range(0, width - 1));
        if (r < 50) return full;
        return (HELPER_TASKS)'($urandom) & full;
    endfunction

    // Scan starts just after the last position, wraps, and ends on it.
    function automatic bit next_alive(input logic [HELPER_TASKS-1:0] mask, input int count,
                                      input int last, output int pick);
        int idx;
        idx = last;
        pick = 0;
        for (int k = 0; k < count; k++) begin
            idx = (idx + 1 < count) ? idx + 1 : 0;
            if (mask[idx]) begin
                pick = idx;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_choice schedule_tick(input t_tick t);
        t_choice c;
        t_class  first;
        int      pick;
        case (last_class)
            CLASS_A: first = CLASS_B;
            CLASS_B: first = CLASS_H;
            default: first = CLASS_A;
        endcase
        if (first == CLASS_A && next_alive(HELPER_TASKS'(t.alive_a), GROUP_TASKS,
                                           int'(last_a), pick)) begin
            last_a = GRP_W'(pick);
            last_class = CLASS_A;
            c.cls = CLASS_A;
        end else if (first == CLASS_B && next_alive(HELPER_TASKS'(t.alive_b), GROUP_TASKS,
                                                    int'(last_b), pick)) begin
            last_b = GRP_W'(pick);
            last_class = CLASS_B;
            c.cls = CLASS_B;
        end else if (next_alive(t.alive_h, HELPER_TASKS, int'(last_h), pick)) begin
            last_h = HLP_W'(pick);
            last_class = CLASS_H;
            c.cls = CLASS_H;
        end else begin
            pick = 0;
            c.cls = CLASS_NONE;
        end
        c.idx = CHOSEN_INDEX_W'(pick);
        return c;
    endfunction

    task automatic add_tick(input logic [GROUP_TASKS-1:0] a, input logic [GROUP_TASKS-1:0] b,
                            input logic [HELPER_TASKS-1:0] h, input int gap);
        t_tick t;
        t.alive_a = a;
        t.alive_b = b;
        t.alive_h = h;
        t.wait_drained = 1'b0;
        t.gap = gap;
        tick_queue.push_back(t);
        ticks_total++;
    endtask

    task automatic add_drain();
        t_tick t;
        t = '{default: 0};
        t.wait_drained = 1'b1;
        tick_queue.push_back(t);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !tick_taken) begin
            s_axis_tvalid <= 1'b1;
        end else if (gap_left > 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left--;
        end else if (tick_queue.size() > 0 && tick_queue[0].wait_drained) begin
            s_axis_tvalid <= 1'b0;
            if (expected_choices.size() == 0) begin
                void'(tick_queue.pop_front());
            end
        end else if (tick_queue.size() > 0) begin
            next_tick = tick_queue.pop_front();
            s_axis_tdata <= {{(IN_DATA_W - IN_BITS){1'b0}}, next_tick.alive_h,
                             next_tick.alive_b, next_tick.alive_a};
            s_axis_tvalid <= 1'b1;
            gap_left = next_tick.gap;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            m_axis_tready <= 1'b0;
        end else begin
            if ((choice_taken || $urandom_range(0, 19) == 0) && (choices_out / 150) % 4 != 1) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        wait (ticks_in >= 200);
        hold_off = 1'b1;
        repeat (250) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        t_tick   t;
        t_choice want;
        t_choice got;
        tick_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        choice_taken <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t.alive_a = s_axis_tdata[IN_A_LO +: GROUP_TASKS];
            t.alive_b = s_axis_tdata[IN_B_LO +: GROUP_TASKS];
            t.alive_h = s_axis_tdata[IN_H_LO +: HELPER_TASKS];
            expected_choices.push_back(schedule_tick(t));
            ticks_in++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cls = t_class'(m_axis_tdata[CLASS_W-1:0]);
            got.idx = m_axis_tdata[CLASS_W +: CHOSEN_INDEX_W];
            choices_out++;
            if (expected_choices.size() == 0) begin
                note_mismatch($sformatf("unexpected beat class %0d index %0d",
                                        got.cls, got.idx));
            end else begin
                want = expected_choices.pop_front();
                if (got.cls !== want.cls || got.idx !== want.idx) begin
                    note_mismatch($sformatf("beat %0d: class %0d index %0d, expected %0d %0d",
                                            choices_out, got.cls, got.idx, want.cls, want.idx));
                end
                class_seen[want.cls]++;
            end
        end
    end

    initial begin
        int n;
        add_tick(5'h00, 5'h00, 15'h0000, 0);
        add_tick(5'h1f, 5'h1f, 15'h7fff, 0);
        add_tick(5'h1f, 5'h1f, 15'h7fff, 1);
        add_tick(5'h1f, 5'h1f, 15'h7fff, 0);
        add_tick(5'h00, 5'h00, 15'h4000, 0);
        add_tick(5'h10, 5'h00, 15'h0000, 2);
        add_tick(5'h00, 5'h00, 15'h0000, 0);
        add_tick(5'h00, 5'h01, 15'h0001, 0);
        add_tick(5'h1f, 5'h1f, 15'h0000, 0);
        add_tick(5'h01, 5'h10, 15'h0001, 0);
        add_tick(5'h01, 5'h00, 15'h0000, 0);
        add_tick(5'h00, 5'h10, 15'h0000, 0);
        add_tick(5'h00, 5'h00, 15'h0001, 0);
        add_tick(5'h01, 5'h00, 15'h0000, 0);
        add_tick(5'h00, 5'h00, 15'h0002, 0);
        add_tick(5'h00, 5'h1f, 15'h0000, 0);
        add_tick(5'h15, 5'h0a, 15'h5555, 0);
        add_tick(5'h0a, 5'h15, 15'h2aaa, 3);
        add_tick(5'h0a, 5'h15, 15'h2aaa, 0);
        add_tick(5'h00, 5'h00, 15'h2000, 0);
        add_tick(5'h08, 5'h04, 15'h0000, 0);
        add_tick(5'h1f, 5'h00, 15'h7fff, 0);
        add_drain();
        for (n = 0; n < 900; n++) begin
            if (n == 450 || n == 700) begin
                add_drain();
            end
            add_tick(GROUP_TASKS'(random_mask(GROUP_TASKS)), GROUP_TASKS'(random_mask(GROUP_TASKS)),
                     random_mask(HELPER_TASKS), ((n / 150) % 4 == 3) ? 0 : idle_len());
        end
        wait (tick_queue.size() == 0 && ticks_in == ticks_total && expected_choices.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("Ran %0d ticks: %0d group A, %0d group B, %0d helper, %0d with nothing alive.",
                 ticks_in, class_seen[CLASS_A], class_seen[CLASS_B], class_seen[CLASS_H],
                 class_seen[CLASS_NONE]);
        $display("Output stalls included one long hold-off; %0d mismatches.", mismatches);
        if (mismatches == 0 && expected_choices.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
